>>> hw/rtl/lwts_pkg.sv
// shared constants, shape codes and types of the lfo wave table sample block
`default_nettype none
package lwts_pkg;

  localparam int DEF_MAX_COUNT = 1024;
  localparam int DEF_MAX_LEVEL = 4095;

  localparam int IDX_W      = 10;
  localparam int CNT_W      = 11;
  localparam int SHAPE_W    = 3;
  localparam int LEVEL_W    = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] REG_WAVE_SHAPE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT = 1'd1;

  localparam logic [SHAPE_W-1:0] SH_SINE      = 3'd0;
  localparam logic [SHAPE_W-1:0] SH_TRIANGLE  = 3'd1;
  localparam logic [SHAPE_W-1:0] SH_RAMP_UP   = 3'd2;
  localparam logic [SHAPE_W-1:0] SH_RAMP_DN   = 3'd3;
  localparam logic [SHAPE_W-1:0] SH_TRAPEZOID = 3'd4;
  localparam logic [SHAPE_W-1:0] SH_SMOOTH_UP = 3'd5;
  localparam logic [SHAPE_W-1:0] SH_SMOOTH_DN = 3'd6;
  localparam logic [SHAPE_W-1:0] SH_POWER     = 3'd7;

  // how the quotient turns into the final level
  typedef struct packed {
    logic err;   // index past last, level 0
    logic flat;  // trapezoid plateau, level at maximum
    logic inv;   // level is maximum minus quotient
  } lwts_flags_t;

endpackage
`default_nettype wire

>>> hw/rtl/lwts_if.sv
// stream interfaces for the sample index and level channels
`default_nettype none
interface lwts_in_if import lwts_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [IDX_W-1:0]   sample_index;
  modport source (output valid, output sample_index, input ready);
  modport sink   (input valid, input sample_index, output ready);
endinterface

interface lwts_out_if import lwts_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] level;
  logic               index_error;
  modport source (output valid, output level, output index_error, input ready);
  modport sink   (input valid, input level, input index_error, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/lfo_wave_table_sample.sv
// top level of the lfo wave table sample block
//
//   channel   dir  handshake          payload
//   in_port   in   valid/ready        sample_index[9:0]
//   out_port  out  valid/ready        level[15:0], index_error
//   cfg_*     in   cfg_we, no ready   cfg_index[0], cfg_data[10:0]
//
// one word per cycle sustained while out_port.ready stays high; the path runs through
// six setup stages, one cell per quotient bit, one output stage
// reset sets wave_shape to 0, sample_count to 1024 and empties the pipeline
// each stage holds while the next is full and cannot move on; in_port.ready falls only when all are full
`default_nettype none
module lfo_wave_table_sample import lwts_pkg::*; #(
  parameter int MAX_COUNT = DEF_MAX_COUNT,
  parameter int MAX_LEVEL = DEF_MAX_LEVEL
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  lwts_in_if.sink                    in_port,
  lwts_out_if.source                 out_port,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int LW = $clog2(MAX_COUNT);
  localparam int MW = $clog2(MAX_LEVEL + 1);
  localparam int W  = 5*LW + 8;
  localparam int PW = W + MW;

  logic [SHAPE_W-1:0] shape_r;
  logic [CNT_W-1:0]   count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shape_r <= SH_SINE;
      count_r <= CNT_W'(1024);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WAVE_SHAPE:   shape_r <= cfg_data[SHAPE_W-1:0];
        REG_SAMPLE_COUNT: count_r <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  logic          c_valid [MW+1];
  logic          c_ready [MW+1];
  logic [PW-1:0] c_rem   [MW+1];
  logic [W-1:0]  c_div   [MW+1];
  logic [MW-1:0] c_quo   [MW+1];
  lwts_flags_t   c_flags [MW+1];

  lwts_prep #(.MAX_COUNT(MAX_COUNT), .MAX_LEVEL(MAX_LEVEL)) u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_port.valid),
    .in_ready (in_port.ready),
    .in_index (in_port.sample_index),
    .shape    (shape_r),
    .count    (count_r),
    .dn_ready (c_ready[0]),
    .dn_valid (c_valid[0]),
    .dn_p     (c_rem[0]),
    .dn_d     (c_div[0]),
    .dn_flags (c_flags[0])
  );

  assign c_quo[0] = '0;

  // quotient bits from the top down, one per cell
  for (genvar i = 0; i < MW; i++) begin : g_cell
    lwts_div_cell #(
      .MAX_COUNT (MAX_COUNT),
      .MAX_LEVEL (MAX_LEVEL),
      .STEP      (MW - 1 - i)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (c_valid[i]),
      .up_ready (c_ready[i]),
      .up_rem   (c_rem[i]),
      .up_div   (c_div[i]),
      .up_quo   (c_quo[i]),
      .up_flags (c_flags[i]),
      .dn_ready (c_ready[i+1]),
      .dn_valid (c_valid[i+1]),
      .dn_rem   (c_rem[i+1]),
      .dn_div   (c_div[i+1]),
      .dn_quo   (c_quo[i+1]),
      .dn_flags (c_flags[i+1])
    );
  end

  logic               out_valid_r;
  logic               out_en;
  logic [LEVEL_W-1:0] level_nxt, level_r;
  logic               ierr_r;
  lwts_flags_t        fl;

  assign out_en      = !out_valid_r || out_port.ready;
  assign c_ready[MW] = out_en;

  always_comb begin
    fl = c_flags[MW];
    if (fl.err) level_nxt = '0;
    else if (fl.flat) level_nxt = LEVEL_W'(MAX_LEVEL);
    else if (fl.inv) level_nxt = LEVEL_W'(MW'(MAX_LEVEL) - c_quo[MW]);
    else level_nxt = LEVEL_W'(c_quo[MW]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_en) begin
      out_valid_r <= c_valid[MW];
    end
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      level_r <= level_nxt;
      ierr_r  <= fl.err;
    end
  end

  assign out_port.valid       = out_valid_r;
  assign out_port.level       = level_r;
  assign out_port.index_error = ierr_r;

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_port.valid && out_port.index_error |-> out_port.level == '0)
    else $error("index error word with nonzero level");

  a_level_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_port.valid |-> out_port.level <= LEVEL_W'(MAX_LEVEL))
    else $error("level above maximum");

  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_port.valid |-> in_port.ready)
    else $error("input stalled with empty output");

endmodule
`default_nettype wire

>>> hw/rtl/lwts_prep.sv
// front pipeline: forms the dividend level*N and the divisor D for each shape
`default_nettype none
module lwts_prep import lwts_pkg::*; #(
  parameter int MAX_COUNT = DEF_MAX_COUNT,
  parameter int MAX_LEVEL = DEF_MAX_LEVEL
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [IDX_W-1:0]     in_index,
  input  wire logic [SHAPE_W-1:0]   shape,
  input  wire logic [CNT_W-1:0]     count,
  input  wire logic                 dn_ready,
  output logic                      dn_valid,
  output logic [5*$clog2(MAX_COUNT)+8+$clog2(MAX_LEVEL+1)-1:0] dn_p,
  output logic [5*$clog2(MAX_COUNT)+8-1:0]                     dn_d,
  output lwts_flags_t               dn_flags
);

  localparam int LW = $clog2(MAX_COUNT);
  localparam int MW = $clog2(MAX_LEVEL + 1);
  localparam int W  = 5*LW + 8;
  localparam int HW = (W + 1) / 2;
  localparam int PW = W + MW;
  localparam int CW = CNT_W + 2;
  localparam int XW = (LW > IDX_W) ? LW : IDX_W;
  localparam int NS = 6;

  logic [NS-1:0] vld_r;
  logic [NS-1:0] en;

  always_comb begin
    en[NS-1] = !vld_r[NS-1] || dn_ready;
    for (int i = NS-2; i >= 0; i--) begin
      en[i] = !vld_r[i] || en[i+1];
    end
  end

  assign in_ready = en[0];
  assign dn_valid = vld_r[NS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) vld_r[0] <= in_valid;
      for (int i = 1; i < NS; i++) begin
        if (en[i]) vld_r[i] <= vld_r[i-1];
      end
    end
  end

  // stage 0: clamp the count, check the index
  logic [CW-1:0] cnt_ext, cnt_c, last_full;
  logic [XW-1:0] x_cmp, l_cmp;
  logic [LW-1:0] x0_r, l0_r;
  logic [SHAPE_W-1:0] sh0_r;
  logic err0_r;

  always_comb begin
    cnt_ext = CW'(count);
    if (cnt_ext < CW'(2)) cnt_c = CW'(2);
    else if (cnt_ext > CW'(MAX_COUNT)) cnt_c = CW'(MAX_COUNT);
    else cnt_c = cnt_ext;
    last_full = cnt_c - CW'(1);
    x_cmp = XW'(in_index);
    l_cmp = XW'(last_full[LW-1:0]);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      x0_r   <= x_cmp[LW-1:0];
      l0_r   <= last_full[LW-1:0];
      sh0_r  <= shape;
      err0_r <= x_cmp > l_cmp;
    end
  end

  // stage 1: first products and the linear shapes
  logic [LW:0]    two_x, l_ext, two_x_ml;
  logic           first_half;
  logic [LW-1:0]  v_nxt, lmx;
  logic [LW+1:0]  four_x, four_lmx, l_w, three_l, t_nxt, nlin_nxt;
  lwts_flags_t    fl_nxt;
  logic [2*LW-1:0] q1_nxt, xx1_nxt, ll1_nxt, v21_nxt;

  logic [2*LW-1:0] q1_r, xx1_r, ll1_r, v21_r;
  logic [LW-1:0]   v1_r, l1_r;
  logic [LW+1:0]   t1_r, nlin1_r;
  logic [SHAPE_W-1:0] sh1_r;
  lwts_flags_t     fl1_r;

  always_comb begin
    two_x      = {x0_r, 1'b0};
    l_ext      = {1'b0, l0_r};
    two_x_ml   = two_x - l_ext;
    first_half = two_x <= l_ext;
    v_nxt      = first_half ? two_x[LW-1:0] : two_x_ml[LW-1:0];
    lmx        = l0_r - x0_r;
    four_x     = {x0_r, 2'b00};
    four_lmx   = {lmx, 2'b00};
    l_w        = (LW+2)'(l0_r);
    three_l    = (LW+2)'({l0_r, 1'b0}) + l_w;
    t_nxt      = three_l - (LW+2)'(two_x);
    q1_nxt     = x0_r * lmx;
    xx1_nxt    = x0_r * x0_r;
    ll1_nxt    = l0_r * l0_r;
    v21_nxt    = v_nxt * v_nxt;
    fl_nxt.err  = err0_r;
    fl_nxt.flat = 1'b0;
    fl_nxt.inv  = 1'b0;
    nlin_nxt    = '0;
    case (sh0_r)
      SH_TRIANGLE: begin
        nlin_nxt = first_half ? (LW+2)'(two_x) : (LW+2)'({lmx, 1'b0});
      end
      SH_RAMP_UP: begin
        nlin_nxt = (LW+2)'(x0_r);
      end
      SH_RAMP_DN: begin
        nlin_nxt = (LW+2)'(lmx);
      end
      SH_TRAPEZOID: begin
        if (four_x < l_w) nlin_nxt = four_x;
        else if (four_x <= three_l) fl_nxt.flat = 1'b1;
        else nlin_nxt = four_lmx;
      end
      SH_SMOOTH_DN: begin
        fl_nxt.inv = 1'b1;
      end
      SH_POWER: begin
        fl_nxt.inv = !first_half;
      end
      default: begin
        nlin_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      q1_r    <= q1_nxt;
      xx1_r   <= xx1_nxt;
      ll1_r   <= ll1_nxt;
      v21_r   <= v21_nxt;
      v1_r    <= v_nxt;
      l1_r    <= l0_r;
      t1_r    <= t_nxt;
      nlin1_r <= nlin_nxt;
      sh1_r   <= sh0_r;
      fl1_r   <= fl_nxt;
    end
  end

  // stage 2: sine numerator and denominator, cubic and fourth powers
  logic [2*LW+3:0] num2_nxt;
  logic [2*LW+2:0] den2_nxt;
  logic [3*LW+1:0] sm2_nxt;
  logic [3*LW-1:0] l32_nxt;
  logic [4*LW-1:0] v42_nxt, l42_nxt;

  logic [2*LW+3:0] num2_r;
  logic [2*LW+2:0] den2_r;
  logic [3*LW+1:0] sm2_r;
  logic [3*LW-1:0] l32_r;
  logic [4*LW-1:0] v42_r, l42_r;
  logic [LW-1:0]   v2_r, l2_r;
  logic [LW+1:0]   nlin2_r;
  logic [SHAPE_W-1:0] sh2_r;
  lwts_flags_t     fl2_r;

  always_comb begin
    num2_nxt = {q1_r, 4'b0000};
    den2_nxt = (2*LW+3)'({ll1_r, 2'b00}) + (2*LW+3)'(ll1_r) - (2*LW+3)'({q1_r, 2'b00});
    sm2_nxt  = xx1_r * t1_r;
    l32_nxt  = ll1_r * l1_r;
    v42_nxt  = v21_r * v21_r;
    l42_nxt  = ll1_r * ll1_r;
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      num2_r  <= num2_nxt;
      den2_r  <= den2_nxt;
      sm2_r   <= sm2_nxt;
      l32_r   <= l32_nxt;
      v42_r   <= v42_nxt;
      l42_r   <= l42_nxt;
      v2_r    <= v1_r;
      l2_r    <= l1_r;
      nlin2_r <= nlin1_r;
      sh2_r   <= sh1_r;
      fl2_r   <= fl1_r;
    end
  end

  // stage 3: last products and shape select
  logic [4*LW+7:0] sqn;
  logic [4*LW+5:0] sqd;
  logic [5*LW-1:0] p5n, p5d;
  logic [W-1:0]    n3_nxt, d3_nxt;
  logic [W-1:0]    n3_r, d3_r;
  lwts_flags_t     fl3_r;

  always_comb begin
    sqn = num2_r * num2_r;
    sqd = den2_r * den2_r;
    p5n = v42_r * v2_r;
    p5d = l42_r * l2_r;
    case (sh2_r)
      SH_SINE: begin
        n3_nxt = W'(sqn);
        d3_nxt = W'(sqd);
      end
      SH_SMOOTH_UP, SH_SMOOTH_DN: begin
        n3_nxt = W'(sm2_r);
        d3_nxt = W'(l32_r);
      end
      SH_POWER: begin
        n3_nxt = W'(p5n);
        d3_nxt = W'(p5d);
      end
      default: begin
        n3_nxt = W'(nlin2_r);
        d3_nxt = W'(l2_r);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      n3_r  <= n3_nxt;
      d3_r  <= d3_nxt;
      fl3_r <= fl2_r;
    end
  end

  // stage 4: scale by the maximum level in two halves
  logic [HW+MW-1:0]     plo_nxt, plo_r;
  logic [W-HW+MW-1:0]   phi_nxt, phi_r;
  logic [W-1:0]         d4_r;
  lwts_flags_t          fl4_r;

  always_comb begin
    plo_nxt = n3_r[HW-1:0] * MW'(MAX_LEVEL);
    phi_nxt = n3_r[W-1:HW] * MW'(MAX_LEVEL);
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      plo_r <= plo_nxt;
      phi_r <= phi_nxt;
      d4_r  <= d3_r;
      fl4_r <= fl3_r;
    end
  end

  // stage 5: join the halves
  logic [PW-1:0] p5_r;
  logic [W-1:0]  d5_r;
  lwts_flags_t   fl5_r;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      p5_r  <= {phi_r, {HW{1'b0}}} + PW'(plo_r);
      d5_r  <= d4_r;
      fl5_r <= fl4_r;
    end
  end

  assign dn_p     = p5_r;
  assign dn_d     = d5_r;
  assign dn_flags = fl5_r;

endmodule
`default_nettype wire

>>> hw/rtl/lwts_div_cell.sv
// one restoring division cell: settles one quotient bit and passes the rest on
`default_nettype none
module lwts_div_cell import lwts_pkg::*; #(
  parameter int MAX_COUNT = DEF_MAX_COUNT,
  parameter int MAX_LEVEL = DEF_MAX_LEVEL,
  parameter int STEP      = 0
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  up_valid,
  output logic       up_ready,
  input  wire logic [5*$clog2(MAX_COUNT)+8+$clog2(MAX_LEVEL+1)-1:0] up_rem,
  input  wire logic [5*$clog2(MAX_COUNT)+8-1:0]                     up_div,
  input  wire logic [$clog2(MAX_LEVEL+1)-1:0]                       up_quo,
  input  wire lwts_flags_t up_flags,
  input  wire logic  dn_ready,
  output logic       dn_valid,
  output logic [5*$clog2(MAX_COUNT)+8+$clog2(MAX_LEVEL+1)-1:0] dn_rem,
  output logic [5*$clog2(MAX_COUNT)+8-1:0]                     dn_div,
  output logic [$clog2(MAX_LEVEL+1)-1:0]                       dn_quo,
  output lwts_flags_t dn_flags
);

  localparam int LW = $clog2(MAX_COUNT);
  localparam int MW = $clog2(MAX_LEVEL + 1);
  localparam int W  = 5*LW + 8;
  localparam int PW = W + MW;

  logic          valid_r;
  logic          en;
  logic [PW-1:0] dsh, rem_nxt, rem_r;
  logic          ge;
  logic [MW-1:0] quo_nxt, quo_r;
  logic [W-1:0]  div_r;
  lwts_flags_t   flags_r;

  assign en       = !valid_r || dn_ready;
  assign up_ready = en;

  always_comb begin
    dsh     = PW'(up_div) << STEP;
    ge      = up_rem >= dsh;
    rem_nxt = ge ? (up_rem - dsh) : up_rem;
    quo_nxt = MW'({up_quo, ge});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r   <= rem_nxt;
      div_r   <= up_div;
      quo_r   <= quo_nxt;
      flags_r <= up_flags;
    end
  end

  assign dn_valid = valid_r;
  assign dn_rem   = rem_r;
  assign dn_div   = div_r;
  assign dn_quo   = quo_r;
  assign dn_flags = flags_r;

endmodule
`default_nettype wire
